// File: design/decimal_display_command_builder_defines.svh
// assertion macros shared by the decimal display command builder modules
// no dependencies; included by every file that asserts
`ifndef DECIMAL_DISPLAY_COMMAND_BUILDER_DEFINES_SVH
`define DECIMAL_DISPLAY_COMMAND_BUILDER_DEFINES_SVH
`ifndef SYNTH
// condition in the same cycle
`define DDCB_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddcb assertion failed");
// condition in the next cycle
`define DDCB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddcb assertion failed");
`else
`define DDCB_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define DDCB_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// File: design/ddcb_pkg.sv
// shared types and constants of the decimal display command builder
// no dependencies
`timescale 1ns / 1ps
package ddcb_pkg;
   localparam int DEFAULT_MAX_DIGITS = 8;
   localparam int VALUE_WIDTH        = 27;
   localparam int DIGIT_W            = 4;
   localparam int COUNT_W            = 4;

   localparam logic [COUNT_W-1:0] DIGIT_COUNT_RESET = 4'd8;
   localparam logic [7:0]         CMD_BLANK         = 8'h80;
   localparam logic [7:0]         CMD_DECODE        = 8'hC8;
   localparam logic [DIGIT_W-1:0] DATA_BLANK        = 4'hF;

   // control of the bcd cell row
   typedef struct packed {
      logic clear;
      logic step;
   } cell_ctl_type;

   // hand-off of a finished conversion to the emitter
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] count;
   } emit_load_type;
endpackage

// File: design/ddcb_cell.sv
// one bcd digit cell of the double-dabble shift chain
// depends on ddcb_pkg
`timescale 1ns / 1ps
module ddcb_cell import ddcb_pkg::*; (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               shift_in,
   output logic               carry_out,
   output logic [DIGIT_W-1:0] digit
);
   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   // add 3 when the digit is 5 or more, so the shift carries correctly
   assign adj       = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
   assign carry_out = adj[DIGIT_W-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.step) begin
         digit_in = {adj[DIGIT_W-2:0], shift_in};
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end
endmodule

// File: design/ddcb_emitter.sv
// walks the converted digits from the top position down and drives the
// registered command/data output; depends on ddcb_pkg and the defines header
`timescale 1ns / 1ps
`include "decimal_display_command_builder_defines.svh"
module ddcb_emitter import ddcb_pkg::*; #(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS,
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  emit_load_type                   load,
   input  logic [MAX_DIGITS*DIGIT_W-1:0]   load_digits,
   output logic                            idle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_command_byte,
   output logic [DIGIT_W-1:0]              rsp_data_byte,
   output logic                            rsp_last_pair
);
   logic [DIGIT_W-1:0] digits_ff [MAX_DIGITS];
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic               active_ff, active_in;
   logic               leading_ff, leading_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [DIGIT_W-1:0] data_ff, data_in;
   logic               last_ff, last_in;
   logic [COUNT_W-1:0] count_sat;
   logic [DIGIT_W-1:0] cur;
   logic               fire;
   logic               blank;

   // counts above the cell row are clamped
   assign count_sat = (load.count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS) : load.count;
   assign cur       = digits_ff[pos_ff];
   assign fire      = active_ff && (!rsp_valid_ff || rsp_ready);
   assign blank     = leading_ff && (cur == '0);
   assign idle      = !active_ff;

   always_comb begin
      pos_in       = pos_ff;
      active_in    = active_ff;
      leading_in   = leading_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_in       = cmd_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         cmd_in       = (blank ? CMD_BLANK : CMD_DECODE) + 8'(pos_ff);
         data_in      = blank ? DATA_BLANK : cur;
         last_in      = (pos_ff == '0);
         leading_in   = blank;
         pos_in       = pos_ff - 1'b1;
         if (pos_ff == '0) begin
            active_in = 1'b0;
         end
      end
      if (load.valid) begin
         active_in  = (count_sat != '0);
         leading_in = 1'b1;
         pos_in     = IDX_W'(count_sat - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff     <= pos_in;
      leading_ff <= leading_in;
      cmd_ff     <= cmd_in;
      data_ff    <= data_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digits_ff[i] <= load_digits[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_byte = cmd_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_last_pair    = last_ff;

   `DDCB_ASSERT_NEXT(a_last_ends_run, clock, reset, fire && (pos_ff == '0), !active_ff)
   `DDCB_ASSERT_IMPLY(a_blank_cmd, clock, reset, rsp_valid_ff && (data_ff == DATA_BLANK), cmd_ff < CMD_DECODE)
   `DDCB_ASSERT_IMPLY(a_digit_cmd, clock, reset, rsp_valid_ff && (data_ff != DATA_BLANK), cmd_ff >= CMD_DECODE)
endmodule

// File: design/decimal_display_command_builder.sv
// top level of the decimal display command builder: csr register, bit-serial
// double-dabble cell row and pair emitter; depends on ddcb_pkg, ddcb_cell,
// ddcb_emitter and the defines header
//
// usage:
//  - req channel (valid/ready) carries one 27-bit unsigned value per transaction
//  - rsp channel (valid/ready) returns one command/data pair per display
//    position, highest position first; rsp_last_pair marks position 0
//  - csr_write_enable/csr_write_data set the digit count (reset value 8);
//    write it only while the block is idle; counts above MAX_DIGITS clamp,
//    a count of zero yields no pairs
//  - timing: the value shifts through the bcd cell row one bit a cycle, then
//    hands off to the emitter, which offers one pair per cycle while rsp
//    keeps up
//  - overlap: the next value converts while the previous one's pairs are still
//    being sent
//  - reset clears the control state and drops any transaction in flight
//  - a stalled rsp holds the output register; once the emitter is full the
//    finished conversion waits and req_ready falls
`timescale 1ns / 1ps
`include "decimal_display_command_builder_defines.svh"
module decimal_display_command_builder import ddcb_pkg::*; #(
   parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_command_byte,
   output logic [DIGIT_W-1:0]     rsp_data_byte,
   output logic                   rsp_last_pair,
   input  logic                   csr_write_enable,
   input  logic [COUNT_W-1:0]     csr_write_data
);
   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH + 1);

   // converter sequencer
   typedef enum logic [2:0] {
      CONV_IDLE  = 3'b001,
      CONV_SHIFT = 3'b010,
      CONV_HOLD  = 3'b100
   } conv_state_type;

   conv_state_type             state_ff, state_in;
   logic [BIT_CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [VALUE_WIDTH-1:0]     value_ff, value_in;
   logic [COUNT_W-1:0]         digit_count_ff;
   logic                       accept;
   logic                       xfer;
   logic                       shift_done;
   logic                       emit_idle;
   cell_ctl_type               cell_ctl;
   emit_load_type              emit_load;
   logic [MAX_DIGITS-1:0]      carry;
   logic [MAX_DIGITS*DIGIT_W-1:0] digits;

   // digit count register
   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DIGIT_COUNT_RESET;
      end else if (csr_write_enable) begin
         digit_count_ff <= csr_write_data;
      end
   end

   // a finished conversion moves to the emitter as soon as it is free,
   // and the next value may enter in that same cycle
   assign xfer       = (state_ff == CONV_HOLD) && emit_idle;
   assign req_ready  = (state_ff == CONV_IDLE) || xfer;
   assign accept     = req_valid && req_ready;
   // last bit of the value is being shifted in
   assign shift_done = (state_ff == CONV_SHIFT) && (bit_cnt_ff == BIT_CNT_W'(1));

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      value_in   = value_ff;
      case (state_ff)
         CONV_IDLE: begin
            if (accept) begin
               state_in = CONV_SHIFT;
            end
         end
         CONV_SHIFT: begin
            bit_cnt_in = bit_cnt_ff - 1'b1;
            value_in   = {value_ff[VALUE_WIDTH-2:0], 1'b0};
            if (shift_done) begin
               state_in = CONV_HOLD;
            end
         end
         CONV_HOLD: begin
            if (xfer) begin
               state_in = accept ? CONV_SHIFT : CONV_IDLE;
            end
         end
         default: begin
            state_in = CONV_IDLE;
         end
      endcase
      if (accept) begin
         bit_cnt_in = BIT_CNT_W'(VALUE_WIDTH);
         value_in   = req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      bit_cnt_ff <= bit_cnt_in;
      value_ff   <= value_in;
   end

   // bcd cell row: msb of the value enters cell 0, carries ripple upward
   // one cell per cycle; the top cell's carry is the dropped high digit
   assign cell_ctl.clear = accept;
   assign cell_ctl.step  = (state_ff == CONV_SHIFT);

   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
      logic cell_in;
      if (g == 0) begin : g_first
         assign cell_in = value_ff[VALUE_WIDTH-1];
      end else begin : g_rest
         assign cell_in = carry[g-1];
      end
      ddcb_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .shift_in  (cell_in),
         .carry_out (carry[g]),
         .digit     (digits[g*DIGIT_W +: DIGIT_W])
      );
   end

   assign emit_load.valid = xfer;
   assign emit_load.count = digit_count_ff;

   ddcb_emitter #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_emitter (
      .clock            (clock),
      .reset            (reset),
      .load             (emit_load),
      .load_digits      (digits),
      .idle             (emit_idle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_byte (rsp_command_byte),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last_pair    (rsp_last_pair)
   );

   `DDCB_ASSERT_IMPLY(a_no_accept_in_shift, clock, reset, state_ff == CONV_SHIFT, !req_ready)
   `DDCB_ASSERT_NEXT(a_shift_ends, clock, reset, shift_done, state_ff == CONV_HOLD)
   `DDCB_ASSERT_NEXT(a_hold_waits, clock, reset, (state_ff == CONV_HOLD) && !emit_idle, state_ff == CONV_HOLD)
endmodule

// File: verif/tb.sv
// self-checking testbench for decimal_display_command_builder: drives values and digit
// counts, predicts every command/data pair and checks the rsp channel against it
// depends on ddcb_pkg and the decimal_display_command_builder rtl
`timescale 1ns / 1ps
module tb;
   import ddcb_pkg::*;

   // run-wide limits
   localparam int CYCLE_LIMIT  = 500000;  // generous ceiling on the whole run
   localparam int SETTLE_TAIL  = 48;      // covers a conversion that yields no pairs
   localparam int REPORT_LIMIT = 10;      // mismatches shown in full
   localparam int RANDOM_BURST = 29;      // values per random digit-count setting

   // idling schedules
   typedef enum int {
      IDLE_SLOW_RSP,     // sender idles lightly, receiver stalls heavily
      IDLE_SLOW_REQ,     // the other way round
      IDLE_NONE          // both sides at full speed
   } idle_mode_type;

   // one display position as the block should emit it
   typedef struct packed {
      logic [7:0]         command;
      logic [DIGIT_W-1:0] data;
      logic               is_last;
   } display_pair_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_command_byte;
   logic [DIGIT_W-1:0]     rsp_data_byte;
   logic                   rsp_last_pair;
   logic                   csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]     csr_write_data = '0;

   // testbench copy of the digit count register
   logic [COUNT_W-1:0]     digit_count_shadow = DIGIT_COUNT_RESET;

   display_pair_type       pairs_due[$];     // pairs still owed by the block, oldest first
   int                     send_idle_pct = 26;
   int                     rsp_stall_pct = 82;
   int                     values_sent   = 0;
   int                     pairs_checked = 0;
   int                     failures      = 0;
   int                     cycle_count   = 0;
   bit                     counts_seen[16];  // which register settings were exercised

   decimal_display_command_builder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_command_byte (rsp_command_byte),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last_pair    (rsp_last_pair),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pairs still owed", cycle_count,
                  pairs_due.size());
         $display("decimal_display_command_builder verification failed");
         $finish;
      end
   end

   function automatic int unsigned pow10(input int n);
      int unsigned p;
      p = 1;
      for (int k = 0; k < n; k++) p = p * 10;
      return p;
   endfunction

   // only the first few failures get a full printout, the rest are counted
   task automatic note_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("error at cycle %0d: %s", cycle_count, what);
   endtask

   // digit splitting with leading-zero blanking, highest position first
   task automatic predict_pairs(input logic [VALUE_WIDTH-1:0] value);
      int               positions;
      int unsigned      digit;
      bit               leading;
      display_pair_type pair;
      // counts above the position limit clamp, zero means nothing is emitted
      positions = (digit_count_shadow > DEFAULT_MAX_DIGITS) ? DEFAULT_MAX_DIGITS
                                                              : int'(digit_count_shadow);
      leading = 1'b1;
      for (int pos = positions - 1; pos >= 0; pos--) begin
         digit = (value / pow10(pos)) % 10;
         if (digit == 0 && leading) begin
            pair.command = CMD_BLANK + 8'(pos);
            pair.data    = DATA_BLANK;
         end else begin
            // once a non-zero digit shows, every lower zero is decoded
            pair.command = CMD_DECODE + 8'(pos);
            pair.data    = digit[DIGIT_W-1:0];
            leading      = 1'b0;
         end
         pair.is_last = (pos == 0);
         pairs_due.push_back(pair);
      end
   endtask

   // checks every pair that leaves the block and randomizes the rsp stall
   always @(posedge clock) begin : check_pairs
      display_pair_type got;
      display_pair_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_command_byte, rsp_data_byte, rsp_last_pair};
         if (pairs_due.size() == 0) begin
            note_failure($sformatf("unexpected pair cmd=%h data=%h last=%b",
                                   got.command, got.data, got.is_last));
         end else begin
            want = pairs_due.pop_front();
            pairs_checked++;
            if (got.command !== want.command || got.data !== want.data ||
                got.is_last !== want.is_last) begin
               note_failure($sformatf(
                  "pair mismatch: expected cmd=%h data=%h last=%b, got cmd=%h data=%h last=%b",
                  want.command, want.data, want.is_last, got.command, got.data, got.is_last));
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // one req transaction; valid stays up between back-to-back values
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pairs(value);
      values_sent++;
   endtask

   // sender holds off until the block has delivered everything it owes
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pairs_due.size() != 0) @(posedge clock);
   endtask

   // drained plus enough cycles for a conversion that produces no pairs
   task automatic let_block_settle();
      hold_until_drained();
      repeat (SETTLE_TAIL) @(posedge clock);
   endtask

   // register writes happen only with the block idle
   task automatic set_digit_count(input logic [COUNT_W-1:0] count);
      let_block_settle();
      csr_write_enable   <= 1'b1;
      csr_write_data     <= count;
      digit_count_shadow  = count;
      counts_seen[count]  = 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_SLOW_RSP: begin
            send_idle_pct = 26;
            rsp_stall_pct = 82;
         end
         IDLE_SLOW_REQ: begin
            send_idle_pct = 82;
            rsp_stall_pct = 26;
         end
         default: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
      endcase
   endtask

   // mix of full-width noise, in-range values, short numbers and zero-rich numbers
   function automatic logic [VALUE_WIDTH-1:0] random_value();
      int unsigned v;
      case ($urandom_range(0, 3))
         0: v = $urandom & ((1 << VALUE_WIDTH) - 1);
         1: v = $urandom_range(0, 99999999);
         2: v = $urandom_range(0, pow10($urandom_range(1, 8)) - 1);
         default: begin
            v = 0;
            for (int k = 0; k < DEFAULT_MAX_DIGITS; k++) begin
               v = v * 10;
               if ($urandom_range(0, 1) != 0) v = v + $urandom_range(1, 9);
            end
         end
      endcase
      return v[VALUE_WIDTH-1:0];
   endfunction

   // reset value of the register: all eight positions, edge values of the field
   task automatic test_default_count();
      counts_seen[DIGIT_COUNT_RESET] = 1'b1;
      send_value(0);                           // every position blanked
      send_value(99999999);                    // widest in-range value
      send_value({VALUE_WIDTH{1'b1}});         // all bits set, top digit dropped
      send_value(1);                           // blanks down to the last position
      send_value(10203040);                    // zeros inside the number are decoded
      send_value(90000009);
      let_block_settle();
   endtask

   // a single position: only the ones digit survives
   task automatic test_single_digit();
      set_digit_count(1);
      send_value(0);
      send_value(7);
      send_value(99999990);                    // decoded zero would be a blank here
      send_value(99999999);
      let_block_settle();
   endtask

   // counts above the position limit clamp to it
   task automatic test_saturated_count();
      set_digit_count({COUNT_W{1'b1}});
      send_value(123456789);
      send_value(0);
      send_value(5000);
      set_digit_count(COUNT_W'(DEFAULT_MAX_DIGITS + 1));
      send_value(100000000);
      let_block_settle();
   endtask

   // a count of zero yields no pairs at all
   task automatic test_zero_count();
      set_digit_count(0);
      send_value(42);
      send_value(0);
      send_value({VALUE_WIDTH{1'b1}});
      let_block_settle();
   endtask

   // partial width with leading zeros inside the kept digits
   task automatic test_mid_count();
      set_digit_count(4);
      send_value(1000);
      send_value(100);
      send_value(12345670);
      let_block_settle();
   endtask

   // random values under each idling schedule and several register settings
   task automatic test_random_traffic();
      logic [COUNT_W-1:0] settings[4];
      for (int m = IDLE_SLOW_RSP; m <= IDLE_NONE; m++) begin
         let_block_settle();
         set_idling(idle_mode_type'(m));
         settings[0] = COUNT_W'(DEFAULT_MAX_DIGITS);
         settings[1] = COUNT_W'($urandom_range(1, DEFAULT_MAX_DIGITS - 1));
         settings[2] = COUNT_W'($urandom_range(DEFAULT_MAX_DIGITS + 1, (1 << COUNT_W) - 1));
         settings[3] = COUNT_W'($urandom_range(1, DEFAULT_MAX_DIGITS - 1));
         foreach (settings[s]) begin
            set_digit_count(settings[s]);
            for (int i = 0; i < RANDOM_BURST; i++) begin
               // in the second setting's burst the sender pauses midway until the pipeline is empty
               if (i == RANDOM_BURST / 2 && s == 1) hold_until_drained();
               send_value(random_value());
            end
         end
      end
      let_block_settle();
   endtask

   initial begin : run_tests
      int distinct_counts;
      set_idling(IDLE_SLOW_RSP);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_count();
      test_single_digit();
      test_saturated_count();
      test_zero_count();
      test_mid_count();
      test_random_traffic();

      if (pairs_due.size() != 0)
         note_failure($sformatf("%0d pairs never arrived", pairs_due.size()));

      distinct_counts = 0;
      foreach (counts_seen[c]) if (counts_seen[c]) distinct_counts++;
      $display("run covered %0d values and %0d display pairs over %0d cycles",
               values_sent, pairs_checked, cycle_count);
      $display("%0d distinct digit counts incl. zero and clamped, %0d failures",
               distinct_counts, failures);
      if (failures == 0) begin
         $display("decimal_display_command_builder verification clean");
      end else begin
         $display("decimal_display_command_builder verification failed");
      end
      $finish;
   end
endmodule

// File: filelist.f
+incdir+design
design/ddcb_pkg.sv
design/ddcb_cell.sv
design/ddcb_emitter.sv
design/decimal_display_command_builder.sv
verif/tb.sv
